// ===== hdl/clcd_pkg.sv =====
// shared types, codes and step decode helpers for the character lcd bus sequencer
// no dependencies
package clcd_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_BYTE   = 2'd0,
    OP_WRITE_NIBBLE = 2'd1,
    OP_SAMPLE       = 2'd2,
    OP_UNUSED       = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    JOB_BYTE,
    JOB_NIBBLE,
    JOB_STATUS_HIGH,
    JOB_STATUS_BUSY,
    JOB_STATUS_DONE
  } job_t;

  typedef enum logic [2:0] {
    ACT_RS,
    ACT_RW,
    ACT_EN,
    ACT_DRIVE,
    ACT_RELEASE,
    ACT_DONE
  } act_t;

  localparam int StepW = 5;
  localparam int AddrW = 7;

  // steps of a byte write
  localparam logic [StepW-1:0] StepReleaseFirst = 5'd16;
  localparam logic [StepW-1:0] StepStatusRs     = 5'd20;
  localparam logic [StepW-1:0] StepStatusRw     = 5'd21;

  typedef struct packed {
    logic             valid;
    act_t             act;
    logic             level;
    logic [1:0]       pin;
    logic             await_sample;
    logic             last;
    logic [AddrW-1:0] addr;
  } pin_cmd_t;

  // one pin operation of a nibble transfer: rs, rw, e high, d7..d4, e low
  function automatic pin_cmd_t nibble_step(logic [2:0] idx, logic rs, logic [3:0] nib);
    pin_cmd_t c;
    c = '0;
    case (idx)
      3'd0: begin
        c.act = ACT_RS; c.level = rs;
      end
      3'd1: begin
        c.act = ACT_RW; c.level = 1'b0;
      end
      3'd2: begin
        c.act = ACT_EN; c.level = 1'b1;
      end
      3'd3: begin
        c.act = ACT_DRIVE; c.pin = 2'd3; c.level = nib[3];
      end
      3'd4: begin
        c.act = ACT_DRIVE; c.pin = 2'd2; c.level = nib[2];
      end
      3'd5: begin
        c.act = ACT_DRIVE; c.pin = 2'd1; c.level = nib[1];
      end
      3'd6: begin
        c.act = ACT_DRIVE; c.pin = 2'd0; c.level = nib[0];
      end
      default: begin
        c.act = ACT_EN; c.level = 1'b0;
      end
    endcase
    return c;
  endfunction

  function automatic logic [StepW-1:0] job_last(job_t job);
    logic [StepW-1:0] n;
    case (job)
      JOB_BYTE:        n = 5'd22;
      JOB_NIBBLE:      n = 5'd7;
      JOB_STATUS_HIGH: n = 5'd2;
      JOB_STATUS_BUSY: n = 5'd3;
      default:         n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/clcd_in_if.sv =====
// request channel of the character lcd bus sequencer
// depends on nothing
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       reg_select;
  logic [7:0] data_byte;
  logic [3:0] sample_nibble;

  modport source (output valid, opcode, reg_select, data_byte, sample_nibble, input ready);
  modport sink (input valid, opcode, reg_select, data_byte, sample_nibble, output ready);
endinterface

// ===== hdl/clcd_out_if.sv =====
// pin snapshot channel of the character lcd bus sequencer
// depends on nothing
interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic       rs_pin;
  logic       rw_pin;
  logic       enable_pin;
  logic [3:0] data_out;
  logic [3:0] data_drive;
  logic       await_sample;
  logic       done_res;
  logic [6:0] ram_address;
  logic       last;

  modport source (output valid, rs_pin, rw_pin, enable_pin, data_out, data_drive,
                  await_sample, done_res, ram_address, last, input ready);
  modport sink (input valid, rs_pin, rw_pin, enable_pin, data_out, data_drive,
                await_sample, done_res, ram_address, last, output ready);
endinterface

// ===== hdl/clcd_ctrl.sv =====
// request decode, bus phase tracking and step sequencing
// depends on clcd_pkg and clcd_in_if
module clcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  clcd_in_if.sink             in_ch,
  input  logic                adv,
  output clcd_pkg::pin_cmd_t  cmd
);
  import clcd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HIGH   = 2'd1,
    PH_LOW    = 2'd2,
    PH_SPARE  = 2'd3
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [3:0]         status_high_r, status_high_nxt;
  logic               busy_r;
  logic [StepW-1:0]   step_r;
  job_t               job_r, job_nxt;
  logic               rs_r;
  logic [7:0]         byte_r;
  logic [AddrW-1:0]   addr_r, addr_nxt;
  logic               await_r;
  logic               start;
  logic               waiting;
  logic               is_last;
  logic               in_fire;
  pin_cmd_t           op;

  assign waiting = (phase_r == PH_HIGH) || (phase_r == PH_LOW);
  assign is_last = step_r == job_last(job_r);
  assign in_ch.ready = !busy_r || (adv && is_last);
  assign in_fire = in_ch.valid && in_ch.ready;

  // classify the transaction; out-of-place ones start nothing
  always_comb begin
    start           = 1'b0;
    job_nxt         = JOB_NIBBLE;
    phase_nxt       = phase_r;
    status_high_nxt = status_high_r;
    addr_nxt        = '0;
    if (in_ch.opcode == OP_WRITE_BYTE && !waiting) begin
      start     = 1'b1;
      job_nxt   = JOB_BYTE;
      phase_nxt = PH_HIGH;
    end else if (in_ch.opcode == OP_WRITE_NIBBLE && !waiting) begin
      start     = 1'b1;
      job_nxt   = JOB_NIBBLE;
      phase_nxt = PH_IDLE;
    end else if (in_ch.opcode == OP_SAMPLE && phase_r == PH_HIGH) begin
      start           = 1'b1;
      job_nxt         = JOB_STATUS_HIGH;
      status_high_nxt = in_ch.sample_nibble;
      phase_nxt       = PH_LOW;
    end else if (in_ch.opcode == OP_SAMPLE && phase_r == PH_LOW) begin
      start = 1'b1;
      if (status_high_r[3]) begin
        job_nxt   = JOB_STATUS_BUSY;
        phase_nxt = PH_HIGH;
      end else begin
        job_nxt   = JOB_STATUS_DONE;
        addr_nxt  = {status_high_r[2:0], in_ch.sample_nibble};
        phase_nxt = PH_IDLE;
      end
    end
  end

  // pin operation for the current step
  always_comb begin
    op = '0;
    case (job_r)
      JOB_BYTE: begin
        if (step_r < StepReleaseFirst) begin
          op = nibble_step(step_r[2:0], rs_r, step_r[3] ? byte_r[3:0] : byte_r[7:4]);
        end else if (step_r < StepStatusRs) begin
          op.act = ACT_RELEASE;
          op.pin = ~step_r[1:0];
        end else if (step_r == StepStatusRs) begin
          op.act = ACT_RS; op.level = 1'b0;
        end else if (step_r == StepStatusRw) begin
          op.act = ACT_RW; op.level = 1'b1;
        end else begin
          op.act = ACT_EN; op.level = 1'b1;
        end
      end
      JOB_NIBBLE: op = nibble_step(step_r[2:0], rs_r, byte_r[3:0]);
      JOB_STATUS_HIGH: begin
        op.act   = ACT_EN;
        op.level = step_r == 5'd2;
      end
      JOB_STATUS_BUSY: begin
        case (step_r[1:0])
          2'd0: begin
            op.act = ACT_EN; op.level = 1'b0;
          end
          2'd1: begin
            op.act = ACT_RS; op.level = 1'b0;
          end
          2'd2: begin
            op.act = ACT_RW; op.level = 1'b1;
          end
          default: begin
            op.act = ACT_EN; op.level = 1'b1;
          end
        endcase
      end
      default: begin
        if (step_r == '0) begin
          op.act = ACT_EN; op.level = 1'b0;
        end else begin
          op.act = ACT_DONE;
        end
      end
    endcase
    op.valid        = busy_r;
    op.last         = is_last;
    op.await_sample = await_r && is_last;
    op.addr         = addr_r;
  end

  assign cmd = op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      status_high_r <= '0;
      busy_r        <= 1'b0;
      step_r        <= '0;
    end else begin
      if (busy_r && adv) begin
        step_r <= step_r + 5'd1;
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end
      if (in_fire) begin
        phase_r       <= phase_nxt;
        status_high_r <= status_high_nxt;
        if (start) begin
          busy_r  <= 1'b1;
          step_r  <= '0;
          job_r   <= job_nxt;
          rs_r    <= in_ch.reg_select;
          byte_r  <= in_ch.data_byte;
          addr_r  <= addr_nxt;
          await_r <= (phase_nxt == PH_HIGH) || (phase_nxt == PH_LOW);
        end
      end
    end
  end

endmodule

// ===== hdl/clcd_pins.sv =====
// lcd line state and the registered snapshot stage
// depends on clcd_pkg and clcd_out_if
module clcd_pins (
  input  logic                clk,
  input  logic                rst_n,
  input  clcd_pkg::pin_cmd_t  cmd,
  output logic                adv,
  clcd_out_if.source          out_ch
);
  import clcd_pkg::*;

  logic             rs_r, rs_nxt;
  logic             rw_r, rw_nxt;
  logic             en_r, en_nxt;
  logic [3:0]       data_r, data_nxt;
  logic [3:0]       drive_r, drive_nxt;
  logic             done_nxt;
  logic [AddrW-1:0] addr_nxt;
  logic [3:0]       pin_bit;

  logic             valid_r;
  logic             out_rs_r, out_rw_r, out_en_r, out_await_r, out_done_r, out_last_r;
  logic [3:0]       out_data_r, out_drive_r;
  logic [AddrW-1:0] out_addr_r;

  assign adv     = !valid_r || out_ch.ready;
  assign pin_bit = 4'b0001 << cmd.pin;

  always_comb begin
    rs_nxt    = rs_r;
    rw_nxt    = rw_r;
    en_nxt    = en_r;
    data_nxt  = data_r;
    drive_nxt = drive_r;
    done_nxt  = 1'b0;
    addr_nxt  = '0;
    case (cmd.act)
      ACT_RS: rs_nxt = cmd.level;
      ACT_RW: rw_nxt = cmd.level;
      ACT_EN: en_nxt = cmd.level;
      ACT_DRIVE: begin
        drive_nxt = drive_r | pin_bit;
        data_nxt  = cmd.level ? (data_r | pin_bit) : (data_r & ~pin_bit);
      end
      ACT_RELEASE: drive_nxt = drive_r & ~pin_bit;
      ACT_DONE: begin
        rw_nxt   = 1'b0;
        done_nxt = 1'b1;
        addr_nxt = cmd.addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r    <= 1'b0;
      rw_r    <= 1'b0;
      en_r    <= 1'b0;
      data_r  <= '0;
      drive_r <= '0;
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= cmd.valid;
      if (cmd.valid) begin
        rs_r        <= rs_nxt;
        rw_r        <= rw_nxt;
        en_r        <= en_nxt;
        data_r      <= data_nxt;
        drive_r     <= drive_nxt;
        out_rs_r    <= rs_nxt;
        out_rw_r    <= rw_nxt;
        out_en_r    <= en_nxt;
        out_data_r  <= data_nxt;
        out_drive_r <= drive_nxt;
        out_await_r <= cmd.await_sample;
        out_done_r  <= done_nxt;
        out_addr_r  <= addr_nxt;
        out_last_r  <= cmd.last;
      end
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.rs_pin       = out_rs_r;
  assign out_ch.rw_pin       = out_rw_r;
  assign out_ch.enable_pin   = out_en_r;
  assign out_ch.data_out     = out_data_r;
  assign out_ch.data_drive   = out_drive_r;
  assign out_ch.await_sample = out_await_r;
  assign out_ch.done_res     = out_done_r;
  assign out_ch.ram_address  = out_addr_r;
  assign out_ch.last         = out_last_r;

endmodule

// ===== hdl/char_lcd_nibble_bus_sequencer_unit.sv =====
// Character LCD 4-bit bus sequencer. Every request expands into a run of pin operations and
// one snapshot of RS, RW, E, D7..D4 and the data drive enables leaves per operation, one per
// cycle unless a snapshot is held: a byte write with status poll is 23 operations, a lone
// nibble write 8, the sampled high status nibble 3, the sampled low nibble 4 when busy is
// still set and 2 when it is clear (the last of these carries done and the address).
// Requests that do not fit the bus phase are taken and give no snapshot. The step counter
// of the sequencer issues one pin operation a cycle and a held snapshot stalls it; the next
// request is taken in the cycle that issues the last snapshot of the current one.
// depends on clcd_pkg, clcd_in_if, clcd_out_if, clcd_ctrl and clcd_pins
module char_lcd_nibble_bus_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  clcd_in_if.sink     in_ch,
  clcd_out_if.source  out_ch
);
  import clcd_pkg::*;

  pin_cmd_t cmd;
  logic     adv;

  clcd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .cmd   (cmd)
  );

  clcd_pins u_pins (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/sv/clcd_tb_pkg.sv =====
`timescale 1ns / 100ps
// predictor and scoreboard class for the character lcd bus sequencer testbench
// depends on clcd_pkg
package clcd_tb_pkg;
  import clcd_pkg::*;

  typedef enum logic [1:0] {
    BUS_IDLE,
    BUS_WAIT_HIGH,
    BUS_WAIT_LOW
  } bus_phase_t;

  typedef enum int {
    LINE_RS,
    LINE_RW,
    LINE_E,
    LINE_D4,
    LINE_D5,
    LINE_D6,
    LINE_D7
  } lcd_line_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [3:0] dout;
    logic [3:0] drive;
    logic       await_sample;
    logic       done;
    logic [6:0] addr;
    logic       last;
  } pin_snapshot_t;

  class bus_pin_tracker;
    pin_snapshot_t due[$];
    pin_snapshot_t burst[$];
    logic          rs, rw, en;
    logic [3:0]    dout, drive;
    logic [3:0]    status_hi;
    bus_phase_t    phase;
    int            accepted, ignored, checked, dones, errors;

    function new();
      rs = 1'b0;
      rw = 1'b0;
      en = 1'b0;
      dout = 4'h0;
      drive = 4'h0;
      status_hi = 4'h0;
      phase = BUS_IDLE;
    endfunction

    function bit waiting();
      return phase == BUS_WAIT_HIGH || phase == BUS_WAIT_LOW;
    endfunction

    function void take_snapshot(logic done, logic [6:0] addr);
      pin_snapshot_t s;
      s = '0;
      s.rs = rs;
      s.rw = rw;
      s.en = en;
      s.dout = dout;
      s.drive = drive;
      s.done = done;
      s.addr = addr;
      burst.push_back(s);
    endfunction

    function void set_line(lcd_line_t ln, logic lvl);
      int idx;
      case (ln)
        LINE_RS: rs = lvl;
        LINE_RW: rw = lvl;
        LINE_E: en = lvl;
        default: begin
          idx = int'(ln) - int'(LINE_D4);
          drive[idx] = 1'b1;
          dout[idx] = lvl;
        end
      endcase
      take_snapshot(1'b0, 7'h00);
    endfunction

    // a released pin keeps its latched level in dout
    function void release_pin(lcd_line_t ln);
      drive[int'(ln) - int'(LINE_D4)] = 1'b0;
      take_snapshot(1'b0, 7'h00);
    endfunction

    function void nibble_out(logic sel, logic [3:0] nib);
      set_line(LINE_RS, sel);
      set_line(LINE_RW, 1'b0);
      set_line(LINE_E, 1'b1);
      set_line(LINE_D7, nib[3]);
      set_line(LINE_D6, nib[2]);
      set_line(LINE_D5, nib[1]);
      set_line(LINE_D4, nib[0]);
      set_line(LINE_E, 1'b0);
    endfunction

    function void begin_status();
      set_line(LINE_RS, 1'b0);
      set_line(LINE_RW, 1'b1);
      set_line(LINE_E, 1'b1);
      phase = BUS_WAIT_HIGH;
    endfunction

    // works out the snapshots one accepted request causes, returns how many
    function int note_request(opcode_t op, logic sel, logic [7:0] byte_in, logic [3:0] smp);
      int n;
      burst.delete();
      accepted++;
      if (op == OP_WRITE_BYTE && !waiting()) begin
        nibble_out(sel, byte_in[7:4]);
        nibble_out(sel, byte_in[3:0]);
        release_pin(LINE_D7);
        release_pin(LINE_D6);
        release_pin(LINE_D5);
        release_pin(LINE_D4);
        begin_status();
      end else if (op == OP_WRITE_NIBBLE && !waiting()) begin
        nibble_out(sel, byte_in[3:0]);
        phase = BUS_IDLE;
      end else if (op == OP_SAMPLE && phase == BUS_WAIT_HIGH) begin
        status_hi = smp;
        set_line(LINE_E, 1'b0);
        set_line(LINE_E, 1'b0);
        set_line(LINE_E, 1'b1);
        phase = BUS_WAIT_LOW;
      end else if (op == OP_SAMPLE && phase == BUS_WAIT_LOW) begin
        set_line(LINE_E, 1'b0);
        if (status_hi[3]) begin
          begin_status();
        end else begin
          rw = 1'b0;
          take_snapshot(1'b1, {status_hi[2:0], smp});
          phase = BUS_IDLE;
          dones++;
        end
      end
      n = burst.size();
      if (n == 0) begin
        ignored++;
      end else begin
        burst[n-1].last = 1'b1;
        burst[n-1].await_sample = waiting();
      end
      foreach (burst[i]) due.push_back(burst[i]);
      return n;
    endfunction

    function string show(pin_snapshot_t s);
      return $sformatf("rs=%0b rw=%0b e=%0b d=%h drv=%h await=%0b done=%0b addr=%h last=%0b",
                       s.rs, s.rw, s.en, s.dout, s.drive, s.await_sample, s.done, s.addr,
                       s.last);
    endfunction

    function void check_snapshot(pin_snapshot_t got);
      pin_snapshot_t want;
      string diff;
      checked++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb_top: unexpected snapshot %s", show(got));
        return;
      end
      want = due.pop_front();
      diff = "";
      if (got.rs !== want.rs) diff = {diff, " rs"};
      if (got.rw !== want.rw) diff = {diff, " rw"};
      if (got.en !== want.en) diff = {diff, " enable"};
      if (got.dout !== want.dout) diff = {diff, " data_out"};
      if (got.drive !== want.drive) diff = {diff, " data_drive"};
      if (got.await_sample !== want.await_sample) diff = {diff, " await_sample"};
      if (got.done !== want.done) diff = {diff, " done_res"};
      if (got.addr !== want.addr) diff = {diff, " ram_address"};
      if (got.last !== want.last) diff = {diff, " last"};
      if (diff != "") begin
        errors++;
        if (errors <= 10) begin
          $display("tb_top: snapshot %0d differs in%s", checked, diff);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// top level testbench for char_lcd_nibble_bus_sequencer_unit: directed and random requests,
// random stalls on both channels; depends on clcd_pkg, clcd_tb_pkg and the two channel interfaces
module tb_top;
  import clcd_pkg::*;
  import clcd_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic quiet = 1'b0;
  int   productive = 0;

  bus_pin_tracker pins_model = new();

  clcd_in_if  in_ch();
  clcd_out_if out_ch();

  char_lcd_nibble_bus_sequencer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("tb_top: done, errors");
    $finish;
  end

  // receiver: random back-pressure plus two long hold-offs
  initial begin
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done < 2 &&
          pins_model.checked >= (holds_done == 0 ? 700 : 2200)) begin
        hold_left = 120;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk) begin
    pin_snapshot_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.rs = out_ch.rs_pin;
      got.rw = out_ch.rw_pin;
      got.en = out_ch.enable_pin;
      got.dout = out_ch.data_out;
      got.drive = out_ch.data_drive;
      got.await_sample = out_ch.await_sample;
      got.done = out_ch.done_res;
      got.addr = out_ch.ram_address;
      got.last = out_ch.last;
      pins_model.check_snapshot(got);
    end
  end

  // offers one request and returns once the transaction is taken
  task automatic offer(input opcode_t op, input logic sel, input logic [7:0] byte_in,
                       input logic [3:0] smp);
    int n;
    while (!quiet && $urandom_range(99) < 26) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.reg_select <= sel;
    in_ch.data_byte <= byte_in;
    in_ch.sample_nibble <= smp;
    do @(posedge clk); while (!in_ch.ready);
    n = pins_model.note_request(op, sel, byte_in, smp);
    if (n > 0) productive++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pins_model.due.size() != 0) @(posedge clk);
  endtask

  task automatic random_traffic(input int target);
    opcode_t    op;
    logic [3:0] smp;
    bit         paused;
    int         start;
    paused = 1'b0;
    start = productive;
    while (productive - start < target) begin
      quiet = (productive - start >= 100) && (productive - start < 160);
      if (!paused && productive - start >= target / 2) begin
        settle();
        paused = 1'b1;
      end
      smp = 4'($urandom_range(15));
      if ($urandom_range(99) < 12) begin
        op = opcode_t'($urandom_range(3));
      end else if (pins_model.waiting()) begin
        op = OP_SAMPLE;
        // busy flag set now and then so the status poll repeats
        if (pins_model.phase == BUS_WAIT_HIGH) smp[3] = ($urandom_range(99) < 40);
      end else begin
        op = ($urandom_range(99) < 70) ? OP_WRITE_BYTE : OP_WRITE_NIBBLE;
      end
      offer(op, 1'($urandom_range(1)), 8'($urandom_range(255)), smp);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_WRITE_BYTE;
    in_ch.reg_select = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.sample_nibble = 4'h0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ignored requests, busy repoll, done with max and zero address
    offer(OP_WRITE_NIBBLE, 1'b0, 8'h00, 4'h0);
    offer(OP_WRITE_NIBBLE, 1'b1, 8'hff, 4'hf);
    offer(OP_UNUSED, 1'b1, 8'hff, 4'hf);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'hf);
    offer(OP_WRITE_BYTE, 1'b0, 8'h00, 4'h0);
    offer(OP_WRITE_BYTE, 1'b1, 8'hff, 4'hf);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'hf);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'h0);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'h7);
    offer(OP_WRITE_NIBBLE, 1'b1, 8'h0f, 4'h0);
    offer(OP_SAMPLE, 1'b1, 8'hff, 4'hf);
    offer(OP_WRITE_BYTE, 1'b1, 8'hff, 4'h0);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'h0);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'h0);
    offer(OP_WRITE_BYTE, 1'b1, 8'ha5, 4'h0);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'h8);
    offer(OP_UNUSED, 1'b0, 8'h00, 4'h0);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'h3);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'h5);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'ha);
    offer(OP_WRITE_BYTE, 1'b0, 8'h5a, 4'h0);
    offer(OP_SAMPLE, 1'b1, 8'h00, 4'hf);
    offer(OP_SAMPLE, 1'b0, 8'h00, 4'h0);
    settle();

    random_traffic(360);
    settle();
    repeat (30) @(posedge clk);

    $display("tb_top: %0d requests taken (%0d ignored), %0d pin snapshots checked",
             pins_model.accepted, pins_model.ignored, pins_model.checked);
    $display("tb_top: %0d byte writes completed with address report, %0d mismatches",
             pins_model.dones, pins_model.errors);
    if (pins_model.errors == 0 && pins_model.due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
